FILE: src/sld_pkg.sv
// Shared types and constants for the sleep session detector.
`timescale 1ns / 1ps
package sld_pkg;

    localparam int TIME_BITS = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 22;

    localparam logic signed [16:0] NOMINAL_MG = 17'sd1000;

    // sample word modes: feed a reading, or wipe the session counters
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic [15:0] RST_STILL_THR = 16'd100;
    localparam logic [7:0]  RST_ONSET     = 8'd10;
    localparam logic [7:0]  RST_WAKE      = 8'd3;
    localparam logic [19:0] RST_GAP       = 20'd15000;
    localparam logic [21:0] RST_BUCKET    = 22'd60000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STILL_THR = 3'd0,
        CFG_ONSET     = 3'd1,
        CFG_WAKE      = 3'd2,
        CFG_GAP       = 3'd3,
        CFG_BUCKET    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] still_threshold_mg;
        logic [7:0]  onset_minutes;
        logic [7:0]  wake_confirm;
        logic [19:0] gap_limit_ms;
        logic [21:0] bucket_length_ms;
    } t_cfg;

    typedef struct packed {
        logic                  mode;
        logic signed [15:0]    accel_mg;
        logic [TIME_BITS-1:0]  time_ms;
        logic [31:0]           step_total;
    } t_item;

    typedef struct packed {
        logic                  primed;
        logic [TIME_BITS-1:0]  bkt_start;
        logic [TIME_BITS-1:0]  last_time;
        logic [15:0]           peak_dev;
        logic [31:0]           step_snap;
        logic                  sleeping;
        logic [15:0]           calm_run;
        logic [15:0]           act_run;
        logic [15:0]           session_cnt;
        logic [15:0]           restless_cnt;
        logic [31:0]           total_cnt;
    } t_state;

    typedef struct packed {
        logic        asleep;
        logic [15:0] session_min;
        logic [15:0] total_min;
        logic [15:0] restless_min;
        logic        minute_closed;
    } t_result;

endpackage

FILE: src/sld_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration words.
`timescale 1ns / 1ps
interface sld_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [15:0]            accel_mg;
    logic [sld_pkg::TIME_BITS-1:0] time_ms;
    logic [31:0]                   step_total;
    modport source (output valid, mode, accel_mg, time_ms, step_total, input ready);
    modport sink   (input valid, mode, accel_mg, time_ms, step_total, output ready);
endinterface

interface sld_out_if;
    logic        valid;
    logic        ready;
    logic        asleep;
    logic [15:0] session_min;
    logic [15:0] total_min;
    logic [15:0] restless_min;
    logic        minute_closed;
    modport source (output valid, asleep, session_min, total_min, restless_min,
                    minute_closed, input ready);
    modport sink   (input valid, asleep, session_min, total_min, restless_min,
                    minute_closed, output ready);
endinterface

interface sld_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sld_pkg::CFG_IDX_BITS-1:0]  index;
    logic [sld_pkg::CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/sleep_session_detector.sv
// Top level of the sleep session detector: input stage, state and result register.
// An accepted sample word is held in the input register; its result word is then
//   registered in the result register. Throughput: one word per cycle while o_out
//   is ready; the judgment is one pass of compare and counter logic in between.
// Reset (i_rst_n low, synchronous): pipeline empty, detector state cleared,
//   configuration back to its defaults (threshold 100, onset 10, confirm 3,
//   gap 15000 ms, bucket 60000 ms).
`timescale 1ns / 1ps
module sleep_session_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sld_in_if.sink    i_in,
    sld_out_if.source o_out,
    sld_cfg_if.sink   i_cfg
);
    import sld_pkg::*;

    // input stage
    logic    r_in_valid;
    t_item   r_item;

    // detector state, updated once per processed word
    t_state  r_state;
    t_state  n_state;

    // result stage
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;

    t_cfg    cfg;
    logic    advance;

    sld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sld_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Advance the held word when the result register is free or drains this cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid         = r_out_valid;
    assign o_out.asleep        = r_result.asleep;
    assign o_out.session_min   = r_result.session_min;
    assign o_out.total_min     = r_result.total_min;
    assign o_out.restless_min  = r_result.restless_min;
    assign o_out.minute_closed = r_result.minute_closed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Capture a new word whenever the input stage is free.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.mode       <= i_in.mode;
            r_item.accel_mg   <= i_in.accel_mg;
            r_item.time_ms    <= i_in.time_ms;
            r_item.step_total <= i_in.step_total;
        end
    end

    // Commit state and result together so each word sees its predecessor's state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

endmodule

FILE: src/sld_cfg.sv
// Configuration register file of the sleep session detector.
`timescale 1ns / 1ps
module sld_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sld_cfg_if.sink       i_cfg,
    output sld_pkg::t_cfg o_cfg
);
    import sld_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_STILL_THR: n_cfg.still_threshold_mg = i_cfg.data[15:0];
                CFG_ONSET:     n_cfg.onset_minutes      = i_cfg.data[7:0];
                CFG_WAKE:      n_cfg.wake_confirm       = i_cfg.data[7:0];
                CFG_GAP:       n_cfg.gap_limit_ms       = i_cfg.data[19:0];
                CFG_BUCKET:    n_cfg.bucket_length_ms   = i_cfg.data[21:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.still_threshold_mg <= RST_STILL_THR;
            r_cfg.onset_minutes      <= RST_ONSET;
            r_cfg.wake_confirm       <= RST_WAKE;
            r_cfg.gap_limit_ms       <= RST_GAP;
            r_cfg.bucket_length_ms   <= RST_BUCKET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: src/sld_step.sv
// Next detector state and result word for one registered item.
`timescale 1ns / 1ps
module sld_step (
    input  sld_pkg::t_cfg    i_cfg,
    input  sld_pkg::t_state  i_state,
    input  sld_pkg::t_item   i_item,
    output sld_pkg::t_state  o_state,
    output sld_pkg::t_result o_result
);
    import sld_pkg::*;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sub_floor32(input logic [31:0] a, input logic [15:0] b);
        return ({16'b0, b} < a) ? a - {16'b0, b} : 32'd0;
    endfunction

    function automatic logic [15:0] sub_floor16(input logic [15:0] a, input logic [15:0] b);
        return (b < a) ? a - b : 16'd0;
    endfunction

    logic signed [16:0]   diff;
    logic [16:0]          diff_mag;
    logic [15:0]          dev;
    logic [TIME_BITS:0]   since;
    logic [TIME_BITS:0]   elapsed;
    logic                 gap;
    logic                 due;
    logic [15:0]          peak_new;
    logic                 still;
    logic [15:0]          still_new;
    logic [15:0]          active_new;
    logic [15:0]          rest_inc;
    logic [15:0]          back;
    logic                 closed;
    t_state               n_st;

    always_comb begin
        diff     = {i_item.accel_mg[15], i_item.accel_mg} - NOMINAL_MG;
        diff_mag = diff[16] ? (~diff) + 17'd1 : diff;
        dev      = diff_mag[15:0];

        // negative spans count as zero: no gap and no bucket close
        since   = {1'b0, i_item.time_ms} - {1'b0, i_state.last_time};
        elapsed = {1'b0, i_item.time_ms} - {1'b0, i_state.bkt_start};
        gap     = !since[TIME_BITS] &&
                  (since[TIME_BITS-1:0] > TIME_BITS'(i_cfg.gap_limit_ms));
        due     = !elapsed[TIME_BITS] &&
                  (elapsed[TIME_BITS-1:0] >= TIME_BITS'(i_cfg.bucket_length_ms));

        peak_new   = (dev > i_state.peak_dev) ? dev : i_state.peak_dev;
        still      = (peak_new < i_cfg.still_threshold_mg) &&
                     !(i_item.step_total > i_state.step_snap);
        still_new  = still ? inc16(i_state.calm_run) : 16'd0;
        active_new = still ? 16'd0 : inc16(i_state.act_run);
        rest_inc   = inc16(i_state.restless_cnt);
        back       = i_state.sleeping ? i_state.act_run : 16'd0;

        n_st   = i_state;
        closed = 1'b0;

        if (i_item.mode == MODE_CLEAR) begin
            n_st.sleeping     = 1'b0;
            n_st.calm_run     = 16'd0;
            n_st.act_run      = 16'd0;
            n_st.session_cnt  = 16'd0;
            n_st.restless_cnt = 16'd0;
            n_st.total_cnt    = 32'd0;
            n_st.peak_dev     = 16'd0;
            n_st.step_snap    = i_item.step_total;
        end else begin
            n_st.last_time = i_item.time_ms;
            if (!i_state.primed) begin
                n_st.primed    = 1'b1;
                n_st.bkt_start = i_item.time_ms;
                n_st.peak_dev  = 16'd0;
                n_st.step_snap = i_item.step_total;
            end else if (gap) begin
                n_st.total_cnt    = sub_floor32(i_state.total_cnt, back);
                n_st.restless_cnt = sub_floor16(i_state.restless_cnt, back);
                n_st.sleeping     = 1'b0;
                n_st.session_cnt  = 16'd0;
                n_st.calm_run     = 16'd0;
                n_st.act_run      = 16'd0;
                n_st.bkt_start    = i_item.time_ms;
                n_st.peak_dev     = 16'd0;
                n_st.step_snap    = i_item.step_total;
            end else begin
                n_st.peak_dev = peak_new;
                if (due) begin
                    closed        = 1'b1;
                    n_st.calm_run = still_new;
                    n_st.act_run  = active_new;
                    if (!i_state.sleeping) begin
                        if (still_new >= {8'b0, i_cfg.onset_minutes}) begin
                            n_st.sleeping     = 1'b1;
                            n_st.session_cnt  = {8'b0, i_cfg.onset_minutes};
                            n_st.restless_cnt = 16'd0;
                            n_st.total_cnt    = add_sat32(i_state.total_cnt,
                                                          {8'b0, i_cfg.onset_minutes});
                        end
                    end else if (still) begin
                        n_st.session_cnt = inc16(i_state.session_cnt);
                        n_st.total_cnt   = add_sat32(i_state.total_cnt, 16'd1);
                    end else if (active_new >= {8'b0, i_cfg.wake_confirm}) begin
                        // wake confirmed: back out the provisional active minutes
                        n_st.total_cnt    = sub_floor32(i_state.total_cnt, active_new - 16'd1);
                        n_st.restless_cnt = sub_floor16(rest_inc, active_new);
                        n_st.sleeping     = 1'b0;
                        n_st.session_cnt  = 16'd0;
                        n_st.calm_run     = 16'd0;
                        n_st.act_run      = 16'd0;
                    end else begin
                        n_st.restless_cnt = rest_inc;
                        n_st.session_cnt  = inc16(i_state.session_cnt);
                        n_st.total_cnt    = add_sat32(i_state.total_cnt, 16'd1);
                    end
                    n_st.bkt_start = i_item.time_ms;
                    n_st.peak_dev  = 16'd0;
                    n_st.step_snap = i_item.step_total;
                end
            end
        end

        o_state                = n_st;
        o_result.asleep        = n_st.sleeping;
        o_result.session_min   = n_st.sleeping ? n_st.session_cnt : 16'd0;
        o_result.total_min     = (n_st.total_cnt[31:16] != 16'd0) ? 16'hFFFF
                                                                  : n_st.total_cnt[15:0];
        o_result.restless_min  = n_st.restless_cnt;
        o_result.minute_closed = closed;
    end

endmodule
